// ===== hw/rtl/pstr_pkg.sv =====
// Shared types and constants for the PID step block with trapezoidal integral.
// Used by the channel interfaces, the register file and the top level.
// No dependencies.
`default_nettype none

package pstr_pkg;

   // Field widths of the beats
   localparam int PvWidth     = 16;
   localparam int AdjustWidth = 32;

   // Configuration register widths
   localparam int GainWidth   = 16;
   localparam int CsrAddrW    = 4;
   localparam int CsrDataW    = 32;

   // Internal datapath widths
   localparam int ErrWidth    = 17;  // set_point - process_value
   localparam int DiffWidth   = 18;  // error - previous error
   localparam int IntegWidth  = 20;  // integral, one fraction bit
   localparam int ProdPWidth  = ErrWidth + GainWidth + 1;
   localparam int ProdDWidth  = DiffWidth + GainWidth + 1;
   localparam int ProdIWidth  = IntegWidth + GainWidth + 1;
   localparam int AccWidth    = 40;  // scale-512 sum, bounded well below 2^37
   localparam int FracShift   = 9;   // Q8.8 gains times half-unit scale

   localparam logic [GainWidth-1:0] LimitReset = 16'd50;

   // Register map, word index into the CSR space
   typedef enum logic [1:0] {
      REG_GAIN_P         = 2'd0,
      REG_GAIN_I         = 2'd1,
      REG_GAIN_D         = 2'd2,
      REG_INTEGRAL_LIMIT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [GainWidth-1:0] gain_p;
      logic [GainWidth-1:0] gain_i;
      logic [GainWidth-1:0] gain_d;
      logic [GainWidth-1:0] integral_limit;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pstr_ifs.sv =====
// Valid/ready channel interfaces for the sample beat and the result beat.
// Depends on pstr_pkg for field widths.
`default_nettype none

interface pstr_req_if import pstr_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [PvWidth-1:0]   process_value;
   logic signed [PvWidth-1:0]   set_point;

   modport source (output valid, process_value, set_point, input ready);
   modport sink   (input valid, process_value, set_point, output ready);
endinterface

interface pstr_rsp_if import pstr_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [AdjustWidth-1:0] adjust;
   logic                          integral_cleared;

   modport source (output valid, adjust, integral_cleared, input ready);
   modport sink   (input valid, adjust, integral_cleared, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pstr_csr.sv =====
// APB-style register file holding the gains and the integral limit.
// Depends on pstr_pkg for the register map and the config struct.
`default_nettype none

module pstr_csr import pstr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CsrAddrW-1:0] paddr,
   input  wire logic [CsrDataW-1:0] pwdata,
   output logic      [CsrDataW-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CsrAddrW-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Write decode, one register per access phase
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_GAIN_P:         cfg_in.gain_p         = pwdata[GainWidth-1:0];
            REG_GAIN_I:         cfg_in.gain_i         = pwdata[GainWidth-1:0];
            REG_GAIN_D:         cfg_in.gain_d         = pwdata[GainWidth-1:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = pwdata[GainWidth-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= '0;
         cfg_ff.gain_i         <= '0;
         cfg_ff.gain_d         <= '0;
         cfg_ff.integral_limit <= LimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux
   always_comb begin
      case (index)
         REG_GAIN_P:         prdata = {(CsrDataW-GainWidth)'(0), cfg_ff.gain_p};
         REG_GAIN_I:         prdata = {(CsrDataW-GainWidth)'(0), cfg_ff.gain_i};
         REG_GAIN_D:         prdata = {(CsrDataW-GainWidth)'(0), cfg_ff.gain_d};
         REG_INTEGRAL_LIMIT: prdata = {(CsrDataW-GainWidth)'(0), cfg_ff.integral_limit};
         default:            prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pid_step_trapezoid_reset_core.sv =====
// PID step: error, trapezoidal integral with reset at a limit, Q8.8 gains.
// Top level; depends on pstr_pkg, pstr_ifs and pstr_csr.
//
// One sample beat (process_value, set_point) gives one result beat (adjust,
// integral_cleared). The block is a four-register pipeline: input register,
// error/integral stage (where previous error and integral are updated), a
// product stage with the three gain multipliers, and the output register.
// It takes a new sample every cycle unless stalled; a sample moves on through the
// stages in that order, and each stage holds while the one after it is full, so
// back-pressure on the result side stalls the input only once all four
// registers are occupied. The integral test uses the integral from before
// the current sample; with integral_limit at zero it clears on every sample.
// The adjust output is the scale-512 sum floored to whole units. Gains and
// the limit should be written only while no sample is in flight.
`default_nettype none

module pid_step_trapezoid_reset_core import pstr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   pstr_req_if.sink                 req_chan,
   pstr_rsp_if.source               rsp_chan,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic      [CsrDataW-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type cfg;

   pstr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, out_valid_in;

   // Stage payloads
   logic signed [PvWidth-1:0]     s1_pv_ff, s1_sp_ff;
   logic signed [ErrWidth-1:0]    s2_err_ff;
   logic signed [DiffWidth-1:0]   s2_diff_ff;
   logic signed [IntegWidth-1:0]  s2_integ_ff;
   logic                          s2_cleared_ff;
   logic signed [ProdPWidth-1:0]  s3_prod_p_ff, s3_prod_p_in;
   logic signed [ProdDWidth-1:0]  s3_prod_d_ff, s3_prod_d_in;
   logic signed [ProdIWidth-1:0]  s3_prod_i_ff, s3_prod_i_in;
   logic                          s3_cleared_ff;
   logic signed [AdjustWidth-1:0] out_adjust_ff, out_adjust_in;
   logic                          out_cleared_ff;

   // Loop state
   logic signed [ErrWidth-1:0]    prev_err_ff;
   logic signed [IntegWidth-1:0]  integ_ff;

   // Stage moves
   logic req_accept, s2_load, s3_load, out_load;
   logic s1_free, s2_free, s3_free;

   assign out_load   = s3_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign s3_free    = !s3_valid_ff || out_load;
   assign s3_load    = s2_valid_ff && s3_free;
   assign s2_free    = !s2_valid_ff || s3_load;
   assign s2_load    = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_load;
   assign req_accept = req_chan.valid && s1_free;

   assign req_chan.ready = s1_free;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_load);
   assign s2_valid_in  = s2_load    || (s2_valid_ff && !s3_load);
   assign s3_valid_in  = s3_load    || (s3_valid_ff && !out_load);
   assign out_valid_in = out_load   || (out_valid_ff && !rsp_chan.ready);

   // Error, difference and integral update
   logic signed [ErrWidth-1:0]   err_c;
   logic signed [DiffWidth-1:0]  diff_c;
   logic        [IntegWidth-1:0] mag_c;
   logic        [IntegWidth-1:0] limit2_c;
   logic                         keep_c;
   logic signed [IntegWidth-1:0] integ_in;

   always_comb begin
      err_c    = {s1_sp_ff[PvWidth-1], s1_sp_ff} - {s1_pv_ff[PvWidth-1], s1_pv_ff};
      diff_c   = {err_c[ErrWidth-1], err_c} - {prev_err_ff[ErrWidth-1], prev_err_ff};
      mag_c    = integ_ff[IntegWidth-1] ? -integ_ff : integ_ff;
      // limit is in whole units, the integral in half units
      limit2_c = {(IntegWidth-GainWidth-1)'(0), cfg.integral_limit, 1'b0};
      keep_c   = mag_c < limit2_c;
      if (keep_c) begin
         integ_in = integ_ff
                  + {{(IntegWidth-ErrWidth){err_c[ErrWidth-1]}}, err_c}
                  + {{(IntegWidth-ErrWidth){prev_err_ff[ErrWidth-1]}}, prev_err_ff};
      end else begin
         integ_in = '0;
      end
   end

   // Gain products, gains taken as non-negative
   assign s3_prod_p_in = s2_err_ff   * $signed({1'b0, cfg.gain_p});
   assign s3_prod_d_in = s2_diff_ff  * $signed({1'b0, cfg.gain_d});
   assign s3_prod_i_in = s2_integ_ff * $signed({1'b0, cfg.gain_i});

   // Scale-512 sum, floor to whole units; bounded below 2^36 so no clipping
   logic signed [AccWidth-1:0] acc_c;

   always_comb begin
      acc_c = {{(AccWidth-ProdPWidth-1){s3_prod_p_ff[ProdPWidth-1]}}, s3_prod_p_ff, 1'b0}
            + {{(AccWidth-ProdDWidth-1){s3_prod_d_ff[ProdDWidth-1]}}, s3_prod_d_ff, 1'b0}
            + {{(AccWidth-ProdIWidth){s3_prod_i_ff[ProdIWidth-1]}}, s3_prod_i_ff};
      out_adjust_in = {{(AdjustWidth-AccWidth+FracShift){acc_c[AccWidth-1]}},
                       acc_c[AccWidth-1:FracShift]};
   end

   // Control state and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
         if (s2_load) begin
            prev_err_ff <= err_c;
            integ_ff    <= integ_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pv_ff <= req_chan.process_value;
         s1_sp_ff <= req_chan.set_point;
      end
      if (s2_load) begin
         s2_err_ff     <= err_c;
         s2_diff_ff    <= diff_c;
         s2_integ_ff   <= integ_in;
         s2_cleared_ff <= !keep_c;
      end
      if (s3_load) begin
         s3_prod_p_ff  <= s3_prod_p_in;
         s3_prod_d_ff  <= s3_prod_d_in;
         s3_prod_i_ff  <= s3_prod_i_in;
         s3_cleared_ff <= s2_cleared_ff;
      end
      if (out_load) begin
         out_adjust_ff  <= out_adjust_in;
         out_cleared_ff <= s3_cleared_ff;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.adjust           = out_adjust_ff;
   assign rsp_chan.integral_cleared = out_cleared_ff;

`ifndef SYNTHESIS
   // a cleared step carries a zero integral into the product stage
   a_cleared_zero: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_cleared_ff) |-> (s2_integ_ff == '0))
      else $error("cleared step with non-zero integral");

   // loop state follows the beat that left the input register
   a_state_follows: assert property (@(posedge clock) disable iff (reset)
      s2_load |=> (prev_err_ff == s2_err_ff && integ_ff == s2_integ_ff))
      else $error("loop state out of step with pipeline");

   // a stalled output keeps the product stage occupied
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && out_valid_ff && !rsp_chan.ready) |=> s3_valid_ff)
      else $error("product stage beat lost under stall");
`endif

endmodule

`default_nettype wire

// ===== verif/pid_step_trapezoid_reset_core_tb.sv =====
// Self-checking testbench for pid_step_trapezoid_reset_core: sample beats in, drive beats out.
// A cycle-free predictor of the PID step is checked against every result beat.
// Depends on pstr_pkg, pstr_ifs and the core RTL.

module pid_step_trapezoid_reset_core_tb;
   import pstr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 3000;  // cycles with no beat on either side
   localparam int HoldAt    = 1350;  // sample count at which the long hold-off starts
   localparam int HoldLen   = 300;
   localparam int PrintCap  = 60;

   typedef struct {
      logic signed [PvWidth-1:0] process_value;
      logic signed [PvWidth-1:0] set_point;
   } sample_type;

   typedef struct {
      logic signed [AdjustWidth-1:0] adjust;
      logic                          integral_cleared;
   } drive_type;

   logic                clock = 1'b1;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   pstr_req_if req_if ();
   pstr_rsp_if rsp_if ();

   pid_step_trapezoid_reset_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock, 20 ns period
   always begin
      #10 clock = 1'b0;
      #10 clock = 1'b1;
   end

   sample_type pending_samples [$];
   drive_type  expected_drives [$];

   // Controller state mirrored at the block's widths
   logic [GainWidth-1:0]         gain_shadow [4];
   logic signed [ErrWidth-1:0]   last_error;
   logic signed [IntegWidth-1:0] integral_half;

   int  samples_taken;
   int  samples_queued;
   int  mismatch_count;
   int  idle_cycles;
   int  hold_left;
   bit  hold_done;
   bit  req_taken;
   int  send_gap;
   int  recv_gap;
   bit  sender_idle_en;
   bit  receiver_idle_en;

   task automatic report_mismatch(string msg);
      if (mismatch_count < PrintCap) begin
         $display("%0t ns  mismatch: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   // One PID step: error, trapezoid or clear, scale-512 sum, floor, saturate
   function automatic drive_type pid_predict(sample_type s);
      longint err;
      longint prev;
      longint diff;
      longint integ;
      longint mag;
      longint acc;
      longint whole;
      drive_type r;
      err   = longint'(s.set_point) - longint'(s.process_value);
      prev  = longint'(last_error);
      diff  = err - prev;
      integ = longint'(integral_half);
      mag   = (integ < 0) ? -integ : integ;
      // limit test on the integral held before this sample
      if (mag < 2 * longint'(gain_shadow[REG_INTEGRAL_LIMIT])) begin
         integ = integ + err + prev;
         r.integral_cleared = 1'b0;
      end else begin
         integ = 0;
         r.integral_cleared = 1'b1;
      end
      acc = 2 * longint'(gain_shadow[REG_GAIN_P]) * err
          + 2 * longint'(gain_shadow[REG_GAIN_D]) * diff
          + longint'(gain_shadow[REG_GAIN_I]) * integ;
      whole = acc >>> FracShift;
      if (whole > 64'sd2147483647) whole = 64'sd2147483647;
      if (whole < -64'sd2147483648) whole = -64'sd2147483648;
      r.adjust      = AdjustWidth'(whole);
      last_error    = ErrWidth'(err);
      integral_half = IntegWidth'(integ);
      return r;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Small errors most often, plus wide, full-range and corner samples
   function automatic sample_type random_sample();
      sample_type s;
      int         r;
      int         pv;
      int         sp;
      int         corner [4];
      corner = '{-32768, -1, 0, 32767};
      r  = $urandom_range(0, 99);
      pv = int'($urandom_range(0, 65535)) - 32768;
      if (r < 45) begin
         sp = pv + int'($urandom_range(0, 400)) - 200;
      end else if (r < 70) begin
         sp = pv + int'($urandom_range(0, 12000)) - 6000;
      end else if (r < 90) begin
         sp = int'($urandom_range(0, 65535)) - 32768;
      end else begin
         pv = corner[$urandom_range(0, 3)];
         sp = corner[$urandom_range(0, 3)];
      end
      sp = (sp > 32767) ? 32767 : ((sp < -32768) ? -32768 : sp);
      s.process_value = PvWidth'(pv);
      s.set_point     = PvWidth'(sp);
      return s;
   endfunction

   // Model update and result scoreboard, sampled at the rising edge
   always @(posedge clock) begin
      drive_type  want;
      sample_type got_sample;
      if (reset) begin
         gain_shadow[REG_GAIN_P]         = '0;
         gain_shadow[REG_GAIN_I]         = '0;
         gain_shadow[REG_GAIN_D]         = '0;
         gain_shadow[REG_INTEGRAL_LIMIT] = LimitReset;
         last_error    = '0;
         integral_half = '0;
         samples_taken <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            gain_shadow[csr_paddr[3:2]] = csr_pwdata[GainWidth-1:0];
         end
         // check a result beat against the oldest expectation
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_drives.size() == 0) begin
               report_mismatch($sformatf("result beat with nothing expected, adjust %0d",
                                         rsp_if.adjust));
            end else begin
               want = expected_drives.pop_front();
               if (rsp_if.adjust !== want.adjust) begin
                  report_mismatch($sformatf("adjust %0d, expected %0d",
                                            rsp_if.adjust, want.adjust));
               end
               if (rsp_if.integral_cleared !== want.integral_cleared) begin
                  report_mismatch($sformatf("integral_cleared %b, expected %b",
                                            rsp_if.integral_cleared,
                                            want.integral_cleared));
               end
            end
         end
         // predict from each accepted sample beat
         if (req_if.valid && req_if.ready) begin
            got_sample.process_value = req_if.process_value;
            got_sample.set_point     = req_if.set_point;
            expected_drives.push_back(pid_predict(got_sample));
            samples_taken <= samples_taken + 1;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
   end

   // Sample driver, fed from the pending queue
   always @(negedge clock) begin
      sample_type s;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!req_if.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap     <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            s = pending_samples.pop_front();
            req_if.process_value <= s.process_value;
            req_if.set_point     <= s.set_point;
            req_if.valid         <= 1'b1;
            send_gap             <= sender_idle_en ? pick_gap() : 0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, once, while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && samples_taken == HoldAt) begin
         hold_left <= HoldLen;
         hold_done <= 1'b1;
      end
   end

   // Result receiver with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap     <= 0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap     <= recv_gap - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         recv_gap     <= receiver_idle_en ? pick_gap() : 0;
      end
   end

   // Watchdog: cycles with no beat accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("pid_step_trapezoid_reset_core_tb: done, errors");
         $finish;
      end
   end

   task automatic csr_read_check(reg_index_type idx, logic [GainWidth-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CsrAddrW'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CsrDataW'(value)) begin
         report_mismatch($sformatf("register %s reads %h, expected %h",
                                   idx.name(), csr_prdata, value));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Register write, setup then access, then read back
   task automatic set_register(reg_index_type idx, logic [GainWidth-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CsrAddrW'({idx, 2'b00});
      csr_pwdata  <= CsrDataW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_read_check(idx, value);
   endtask

   task automatic set_gains(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                            logic [15:0] limit);
      set_register(REG_GAIN_P, gp);
      set_register(REG_GAIN_I, gi);
      set_register(REG_GAIN_D, gd);
      set_register(REG_INTEGRAL_LIMIT, limit);
   endtask

   task automatic push_sample(int pv, int sp);
      sample_type s;
      s.process_value = PvWidth'(pv);
      s.set_point     = PvWidth'(sp);
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   task automatic push_random(int count);
      repeat (count) begin
         pending_samples.push_back(random_sample());
         samples_queued++;
      end
   endtask

   // Wait until every queued sample is taken and every result has come back
   task automatic wait_drained();
      @(negedge clock);
      while (samples_taken != samples_queued || expected_drives.size() != 0) begin
         @(negedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.process_value = '0;
      req_if.set_point = '0;
      rsp_if.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      samples_queued   = 0;
      mismatch_count   = 0;
      sender_idle_en   = 1'b1;
      receiver_idle_en = 1'b1;
      // hold reset, then release it at a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values of the registers
      csr_read_check(REG_GAIN_P, 16'd0);
      csr_read_check(REG_GAIN_I, 16'd0);
      csr_read_check(REG_GAIN_D, 16'd0);
      csr_read_check(REG_INTEGRAL_LIMIT, LimitReset);

      // directed: reset gains, extreme errors
      push_sample(0, 0);
      push_sample(32767, -32768);
      push_sample(-32768, 32767);
      push_sample(100, 100);
      wait_drained();

      // directed: full gains and limit, integral grows then flips sign
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_sample(-32768, 32767);
      push_sample(-32768, 32767);
      push_sample(-32768, 32767);
      push_sample(32767, -32768);
      push_sample(32767, -32768);
      push_sample(0, 0);
      push_sample(1, -1);
      wait_drained();

      // directed: zero limit clears on every sample
      set_register(REG_INTEGRAL_LIMIT, 16'd0);
      push_sample(5, 9);
      push_sample(-7, 3);
      push_sample(0, 0);
      wait_drained();

      // directed: tiny limit, integral walks up to the boundary and clears
      set_gains(16'h0100, 16'h0080, 16'h0040, 16'd2);
      push_sample(0, 1);
      push_sample(0, 1);
      push_sample(0, 1);
      push_sample(0, 1);
      push_sample(0, -1);
      push_sample(0, -1);
      wait_drained();

      // random: modest gains, limit in the working range
      set_gains(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
                16'($urandom_range(0, 1024)), 16'($urandom_range(100, 5000)));
      push_random(400);
      wait_drained();

      // random: everything at its maximum
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_random(300);
      wait_drained();

      // random: zero limit, no idling on either side
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b0;
      set_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'd0);
      push_random(200);
      wait_drained();

      // random: zero gains, limit of one
      sender_idle_en   = 1'b1;
      set_gains(16'd0, 16'd0, 16'd0, 16'd1);
      push_random(200);
      wait_drained();

      // random: full-range settings; the long hold-off falls in here
      receiver_idle_en = 1'b1;
      set_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      push_random(400);
      wait_drained();

      // random: small limit, frequent clearing
      set_gains(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 4096)), 16'($urandom_range(1, 300)));
      push_random(400);
      wait_drained();

      if (expected_drives.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_drives.size()));
      end
      if (mismatch_count == 0) begin
         $display("pid_step_trapezoid_reset_core_tb: done, clean");
      end else begin
         $display("pid_step_trapezoid_reset_core_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pstr_pkg.sv
hw/rtl/pstr_ifs.sv
hw/rtl/pstr_csr.sv
hw/rtl/pid_step_trapezoid_reset_core.sv
verif/pid_step_trapezoid_reset_core_tb.sv
